[rtl/assert_macros.svh]
// Assertion helpers, clocked on clk; CHECK_RUN is held off during rst, CHECK_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CHECK_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/cmwe_pkg.sv]
`timescale 1ns / 1ps

package cmwe_pkg;

  localparam int COLUMNS = 160;
  localparam int ROWS    = 200;

  localparam int COL_W   = $clog2(COLUMNS);
  localparam int CMP_W   = ((COL_W > 8) ? COL_W : 8) + 1;
  localparam int OFS_W   = 9;
  localparam int PREV_W  = 5;
  localparam int SUM_W   = OFS_W + 1;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam int MELT_FAST_LIMIT = 16;
  localparam int MELT_STEP       = 8;
  localparam int DELAY_STEP      = 24;
  localparam int OFFSET_MIN      = -15;
  localparam int DRAW_MAX        = 2;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_QUERY = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_MELT  = 2'd1,
    MODE_DELAY = 2'd2
  } wipe_mode_t;

  typedef enum logic {
    REG_WIPE_MODE    = 1'b0,
    REG_CLASSIC_MELT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_TICK,
    ST_DRAIN
  } state_t;

  // Random-walk start offset for one loaded column.
  function automatic logic signed [PREV_W-1:0] load_offset(
    input logic                     first_col,
    input logic [3:0]               draw,
    input logic signed [PREV_W-1:0] prev
  );
    logic [1:0]               d;
    logic signed [PREV_W:0]   v;
    logic signed [PREV_W-1:0] res;
    d = (draw > 4'(DRAW_MAX)) ? 2'(DRAW_MAX) : draw[1:0];
    v = (PREV_W+1)'(prev) + $signed({{(PREV_W-2){1'b0}}, d}) - (PREV_W+1)'(1);
    if (first_col) begin
      res = -$signed({1'b0, draw});
    end else if (v > 0) begin
      res = '0;
    end else if (v < (PREV_W+1)'(OFFSET_MIN)) begin
      res = PREV_W'(OFFSET_MIN);
    end else begin
      res = PREV_W'(v);
    end
    return res;
  endfunction

endpackage

[rtl/column_melt_wipe_engine_unit.sv]
`timescale 1ns / 1ps

// Screen-melt wipe engine: one signed start offset per two-pixel column, kept in a
// single-port-read, single-port-write synchronous RAM of COLUMNS entries. Offsets are
// undefined until loaded; there is no clearing pass after reset. A load item and a
// query for a column out of range are answered from the idle state; an in-range pixel
// query first reads the RAM, then compares and subtracts. A tick item walks the RAM once
// per melt tick, one column per cycle with the write-back overlapped on the next read,
// then drains the last write-back; a tick with the wipe off or zero ticks is answered
// from the idle state with done set. One item is in work at a time. A result waiting on
// m_tready holds off the next item; that item is taken in the cycle the result register empties.
module column_melt_wipe_engine_unit (
  input  logic                                clk,
  input  logic                                rst,
  // tdata: command[1:0], column[9:2], row[17:10], draw[21:18], tick_count[27:22]
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cmwe_pkg::IN_TDATA_W-1:0]     s_tdata,
  // tdata: done_res[0], from_end_screen[1], source_row[9:2]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cmwe_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [1:0]                          cfg_data
);

  `include "assert_macros.svh"

  localparam logic [cmwe_pkg::COL_W-1:0] LAST_COL = cmwe_pkg::COL_W'(cmwe_pkg::COLUMNS - 1);

  // input fields
  logic [1:0] in_cmd;
  logic [7:0] in_col;
  logic [7:0] in_row;
  logic [3:0] in_draw;
  logic [5:0] in_ticks;
  logic       in_range;
  logic       s_fire;

  assign in_cmd   = s_tdata[1:0];
  assign in_col   = s_tdata[9:2];
  assign in_row   = s_tdata[17:10];
  assign in_draw  = s_tdata[21:18];
  assign in_ticks = s_tdata[27:22];
  assign in_range = cmwe_pkg::CMP_W'(in_col) < cmwe_pkg::CMP_W'(cmwe_pkg::COLUMNS);
  assign s_fire   = s_tvalid && s_tready;

  // configuration
  logic [1:0] wipe_mode;
  logic       classic_melt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wipe_mode    <= cmwe_pkg::MODE_MELT;
      classic_melt <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cmwe_pkg::cfg_reg_t'(cfg_index))
        cmwe_pkg::REG_WIPE_MODE:    wipe_mode    <= cfg_data;
        cmwe_pkg::REG_CLASSIC_MELT: classic_melt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // offset RAM
  logic signed [cmwe_pkg::OFS_W-1:0] mem [cmwe_pkg::COLUMNS];
  logic signed [cmwe_pkg::OFS_W-1:0] mem_rdata;
  logic signed [cmwe_pkg::OFS_W-1:0] wr_data;
  logic [cmwe_pkg::COL_W-1:0]        rd_addr;
  logic [cmwe_pkg::COL_W-1:0]        wr_addr;
  logic                              mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rdata <= mem[rd_addr];
  end

  // control and datapath registers
  cmwe_pkg::state_t                  state, state_next;
  logic signed [cmwe_pkg::PREV_W-1:0] prev_offset;
  logic signed [cmwe_pkg::PREV_W-1:0] load_val;
  logic [cmwe_pkg::COL_W-1:0]        rd_col;
  logic [cmwe_pkg::COL_W-1:0]        stage_col;
  logic                              stage_valid;
  logic [5:0]                        ticks_left;
  logic                              moved;
  logic                              delay_mode;
  logic [7:0]                        q_row;
  logic                              out_done, out_end;
  logic [7:0]                        out_row;
  logic                              out_done_next, out_end_next;
  logic [7:0]                        out_row_next;
  logic                              out_load;
  logic                              prev_we;
  logic                              tick_start;
  logic                              wipe_active;

  assign load_val    = cmwe_pkg::load_offset(in_col == 8'd0, in_draw, prev_offset);
  assign wipe_active = (wipe_mode != cmwe_pkg::MODE_OFF) || classic_melt;

  // one melt tick applied to the offset just read
  logic [cmwe_pkg::SUM_W-1:0]        cur_u, dy, sum;
  logic signed [cmwe_pkg::OFS_W-1:0] tick_val;
  logic                              tick_moved;

  always_comb begin
    cur_u      = cmwe_pkg::SUM_W'(mem_rdata[cmwe_pkg::OFS_W-2:0]);
    dy         = '0;
    sum        = cur_u;
    tick_val   = mem_rdata;
    tick_moved = 1'b0;
    if (mem_rdata < 0) begin
      tick_val   = mem_rdata + cmwe_pkg::OFS_W'(1);
      tick_moved = 1'b1;
    end else if (cur_u < cmwe_pkg::SUM_W'(cmwe_pkg::ROWS)) begin
      if (delay_mode) begin
        dy = cmwe_pkg::SUM_W'(cmwe_pkg::DELAY_STEP);
      end else if (cur_u < cmwe_pkg::SUM_W'(cmwe_pkg::MELT_FAST_LIMIT)) begin
        dy = cur_u + cmwe_pkg::SUM_W'(1);
      end else begin
        dy = cmwe_pkg::SUM_W'(cmwe_pkg::MELT_STEP);
      end
      sum = cur_u + dy;
      if (sum >= cmwe_pkg::SUM_W'(cmwe_pkg::ROWS)) begin
        sum = cmwe_pkg::SUM_W'(cmwe_pkg::ROWS);
      end
      tick_val   = $signed(cmwe_pkg::OFS_W'(sum));
      tick_moved = 1'b1;
    end
  end

  // pixel query on the offset just read
  logic [7:0] q_ofs;
  always_comb begin
    q_ofs = (mem_rdata < 0) ? 8'd0 : mem_rdata[7:0];
  end

  // next state and control
  always_comb begin
    state_next    = state;
    s_tready      = (state == cmwe_pkg::ST_IDLE) && (!m_tvalid || m_tready);
    mem_we        = 1'b0;
    wr_addr       = stage_col;
    wr_data       = tick_val;
    rd_addr       = rd_col;
    out_load      = 1'b0;
    out_done_next = 1'b0;
    out_end_next  = 1'b0;
    out_row_next  = '0;
    prev_we       = 1'b0;
    tick_start    = 1'b0;
    case (state)
      cmwe_pkg::ST_IDLE: begin
        rd_addr = cmwe_pkg::COL_W'(in_col);
        if (s_fire) begin
          case (in_cmd)
            cmwe_pkg::CMD_LOAD: begin
              out_load = 1'b1;
              if (in_range) begin
                mem_we  = 1'b1;
                wr_addr = cmwe_pkg::COL_W'(in_col);
                wr_data = cmwe_pkg::OFS_W'(load_val);
                prev_we = 1'b1;
              end
            end
            cmwe_pkg::CMD_TICK: begin
              if (wipe_active && in_ticks != 6'd0) begin
                tick_start = 1'b1;
                state_next = cmwe_pkg::ST_TICK;
              end else begin
                out_load      = 1'b1;
                out_done_next = 1'b1;
              end
            end
            cmwe_pkg::CMD_QUERY: begin
              if (in_range) begin
                state_next = cmwe_pkg::ST_QUERY;
              end else begin
                out_load     = 1'b1;
                out_row_next = in_row;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      cmwe_pkg::ST_QUERY: begin
        out_load   = 1'b1;
        state_next = cmwe_pkg::ST_IDLE;
        if (q_row < q_ofs) begin
          out_end_next = 1'b1;
          out_row_next = q_row;
        end else begin
          out_row_next = q_row - q_ofs;
        end
      end
      cmwe_pkg::ST_TICK: begin
        mem_we = stage_valid;
        if (rd_col == LAST_COL && ticks_left == 6'd1) begin
          state_next = cmwe_pkg::ST_DRAIN;
        end
      end
      cmwe_pkg::ST_DRAIN: begin
        mem_we        = stage_valid;
        out_load      = 1'b1;
        out_done_next = !(moved || (stage_valid && tick_moved));
        state_next    = cmwe_pkg::ST_IDLE;
      end
      default: state_next = cmwe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmwe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_offset <= '0;
    end else if (prev_we) begin
      prev_offset <= load_val;
    end
  end

  // column walk: read at rd_col, write back in the next cycle at stage_col
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= (state == cmwe_pkg::ST_TICK);
    end
  end

  always_ff @(posedge clk) begin
    if (tick_start) begin
      rd_col     <= '0;
      ticks_left <= in_ticks;
      moved      <= 1'b0;
      delay_mode <= (wipe_mode == cmwe_pkg::MODE_DELAY) && !classic_melt;
    end else if (state == cmwe_pkg::ST_TICK) begin
      stage_col <= rd_col;
      if (rd_col == LAST_COL) begin
        rd_col     <= '0;
        ticks_left <= ticks_left - 6'd1;
      end else begin
        rd_col <= rd_col + cmwe_pkg::COL_W'(1);
      end
      if (stage_valid && tick_moved) begin
        moved <= 1'b1;
      end
    end
    if (s_fire) begin
      q_row <= in_row;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_done <= out_done_next;
      out_end  <= out_end_next;
      out_row  <= out_row_next;
    end
  end

  assign m_tdata = {6'd0, out_row, out_end, out_done};

  `CHECK_RUN(a_stage_in_walk,
    stage_valid |-> (state == cmwe_pkg::ST_TICK || state == cmwe_pkg::ST_DRAIN),
    "write-back stage active outside a tick walk")
  `CHECK_RUN(a_drain_gives_result, (state == cmwe_pkg::ST_DRAIN) |=> m_tvalid,
    "tick walk ended without a result")
  `CHECK_RUN(a_query_reads, (s_fire && in_cmd == cmwe_pkg::CMD_QUERY && in_range)
    |=> (state == cmwe_pkg::ST_QUERY), "in-range query did not wait for its read")
  `CHECK_RUN(a_prev_range,
    prev_offset <= 0 && prev_offset >= cmwe_pkg::PREV_W'(cmwe_pkg::OFFSET_MIN),
    "previous offset out of its walk range")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int         CMD_UNUSED  = 3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         WATCHDOG_LIMIT = 40000;

  // last declared field (cmd) in the lowest bits
  typedef struct packed {
    logic [5:0] ticks;
    logic [3:0] draw;
    logic [7:0] row;
    logic [7:0] col;
    logic [1:0] cmd;
  } melt_item_t;

  typedef struct packed {
    logic [7:0] src_row;
    logic       from_end;
    logic       done;
  } melt_result_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [cmwe_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [cmwe_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  cmwe_pkg::cfg_reg_t               cfg_index = cmwe_pkg::REG_WIPE_MODE;
  logic [1:0]                       cfg_data = '0;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // predicted block state
  logic signed [cmwe_pkg::OFS_W-1:0]  col_ofs [cmwe_pkg::COLUMNS];
  logic signed [cmwe_pkg::PREV_W-1:0] last_load_ofs = '0;
  logic [1:0]                         cur_mode = cmwe_pkg::MODE_MELT;
  logic                               cur_classic = 1'b0;

  melt_result_t pending_results [$];

  column_melt_wipe_engine_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (col_ofs[i]) col_ofs[i] = '0;
  end

  function automatic logic signed [cmwe_pkg::PREV_W-1:0] start_offset(
    input bit first, input logic [3:0] draw);
    int v;
    if (first) return cmwe_pkg::PREV_W'(-int'(draw));
    v = int'(last_load_ofs)
        + ((draw > cmwe_pkg::DRAW_MAX) ? cmwe_pkg::DRAW_MAX : int'(draw)) - 1;
    if (v > 0) v = 0;
    else if (v < cmwe_pkg::OFFSET_MIN) v = cmwe_pkg::OFFSET_MIN;
    return cmwe_pkg::PREV_W'(v);
  endfunction

  // one melt tick over all columns; returns 1 if any column moved
  function automatic bit melt_pass(input bit delay);
    bit moved;
    int v;
    int dy;
    moved = 1'b0;
    for (int i = 0; i < cmwe_pkg::COLUMNS; i++) begin
      v = int'(col_ofs[i]);
      if (v < 0) begin
        v++;
        moved = 1'b1;
      end else if (v < cmwe_pkg::ROWS) begin
        if (delay) dy = cmwe_pkg::DELAY_STEP;
        else dy = (v < cmwe_pkg::MELT_FAST_LIMIT) ? v + 1 : cmwe_pkg::MELT_STEP;
        if (v + dy >= cmwe_pkg::ROWS) dy = cmwe_pkg::ROWS - v;
        v += dy;
        moved = 1'b1;
      end
      col_ofs[i] = cmwe_pkg::OFS_W'(v);
    end
    return moved;
  endfunction

  function automatic melt_result_t predict_result(input melt_item_t it);
    melt_result_t r;
    bit still;
    bit delay;
    int v;
    r = '0;
    case (it.cmd)
      cmwe_pkg::CMD_LOAD: begin
        if (it.col < cmwe_pkg::COLUMNS) begin
          last_load_ofs = start_offset(it.col == 0, it.draw);
          col_ofs[it.col] = cmwe_pkg::OFS_W'(last_load_ofs);
        end
      end
      cmwe_pkg::CMD_TICK: begin
        still = 1'b1;
        if (cur_mode != cmwe_pkg::MODE_OFF || cur_classic) begin
          delay = (cur_mode == cmwe_pkg::MODE_DELAY) && !cur_classic;
          for (int t = 0; t < it.ticks; t++)
            if (melt_pass(delay)) still = 1'b0;
        end
        r.done = still;
      end
      cmwe_pkg::CMD_QUERY: begin
        r.src_row = it.row;
        if (it.col < cmwe_pkg::COLUMNS) begin
          v = int'(col_ofs[it.col]);
          if (v < 0) v = 0;
          if (int'(it.row) < v) r.from_end = 1'b1;
          else r.src_row = 8'(int'(it.row) - v);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input int cmd, input int col, input int row, input int draw,
                           input int ticks);
    melt_item_t it;
    it = '{ticks: 6'(ticks), draw: 4'(draw), row: 8'(row), col: 8'(col), cmd: 2'(cmd)};
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cmwe_pkg::IN_TDATA_W'(it);
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_result(it));
  endtask

  // items the block must answer without touching any stored offset
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_item(CMD_UNUSED, $urandom_range(255), $urandom_range(255),
                   $urandom_range(15), $urandom_range(63));
      1: send_item(cmwe_pkg::CMD_LOAD, $urandom_range(255, cmwe_pkg::COLUMNS),
                   $urandom_range(255), $urandom_range(15), $urandom_range(63));
      default: send_item(cmwe_pkg::CMD_QUERY, $urandom_range(255, cmwe_pkg::COLUMNS),
                         $urandom_range(255), $urandom_range(15), $urandom_range(63));
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic classic);
    cfg_valid <= 1'b1;
    cfg_index <= cmwe_pkg::REG_WIPE_MODE;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cur_mode = mode;
    cfg_index <= cmwe_pkg::REG_CLASSIC_MELT;
    cfg_data  <= {1'b0, classic};
    do @(posedge clk); while (!cfg_ready);
    cur_classic = classic;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // nothing here may read an offset: no column is loaded yet
  task automatic test_unloaded_safe();
    send_item(CMD_UNUSED, 255, 255, 15, 63);
    send_item(cmwe_pkg::CMD_LOAD, cmwe_pkg::COLUMNS, 0, 5, 0);
    send_item(cmwe_pkg::CMD_LOAD, 255, 255, 15, 63);
    send_item(cmwe_pkg::CMD_QUERY, cmwe_pkg::COLUMNS, 0, 0, 0);
    send_item(cmwe_pkg::CMD_QUERY, 255, 255, 15, 63);
    send_item(cmwe_pkg::CMD_TICK, 0, 0, 0, 0);
    drain();
    set_config(cmwe_pkg::MODE_OFF, 1'b0);
    send_item(cmwe_pkg::CMD_TICK, 0, 0, 0, 63);
    drain();
    set_config(cmwe_pkg::MODE_MELT, 1'b0);
  endtask

  // first full sweep: deep start, low clamp, climb into the high clamp, saturated draw
  task automatic test_walk_clamps();
    int d;
    for (int c = 0; c < cmwe_pkg::COLUMNS; c++) begin
      if (c == 0 || c == 21) d = 15;
      else if (c < 4) d = 0;
      else if (c < 21) d = 2;
      else d = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(2);
      send_item(cmwe_pkg::CMD_LOAD, c, $urandom_range(255), d, $urandom_range(63));
    end
  endtask

  task automatic test_query_edges();
    send_item(cmwe_pkg::CMD_QUERY, 0, 0, 0, 0);
    send_item(cmwe_pkg::CMD_QUERY, 0, 255, 0, 0);
    send_item(cmwe_pkg::CMD_QUERY, cmwe_pkg::COLUMNS - 1, cmwe_pkg::ROWS - 1, 0, 0);
    send_item(cmwe_pkg::CMD_QUERY, cmwe_pkg::COLUMNS - 1, 0, 0, 0);
    send_item(cmwe_pkg::CMD_TICK, 0, 0, 0, 1);
    send_item(cmwe_pkg::CMD_TICK, 0, 0, 0, 16);
    send_item(cmwe_pkg::CMD_QUERY, 0, 0, 0, 0);
    send_item(cmwe_pkg::CMD_QUERY, 21, 255, 0, 0);
  endtask

  task automatic test_mode_ticks();
    drain();
    set_config(cmwe_pkg::MODE_DELAY, 1'b0);
    send_item(cmwe_pkg::CMD_TICK, 0, 0, 0, 63);    // overshoot saturates at the height
    send_item(cmwe_pkg::CMD_QUERY, 5, cmwe_pkg::ROWS - 1, 0, 0);
    send_item(cmwe_pkg::CMD_QUERY, 5, 255, 0, 0);
    send_item(cmwe_pkg::CMD_TICK, 0, 0, 0, 1);
    drain();
    set_config(MODE_UNUSED, 1'b0);
    send_item(cmwe_pkg::CMD_LOAD, 0, 0, 2, 0);
    send_item(cmwe_pkg::CMD_TICK, 0, 0, 0, 3);
    drain();
    set_config(cmwe_pkg::MODE_OFF, 1'b1);
    send_item(cmwe_pkg::CMD_LOAD, 7, 0, 0, 0);
    send_item(cmwe_pkg::CMD_TICK, 0, 0, 0, 2);
    send_item(cmwe_pkg::CMD_QUERY, 7, 0, 0, 0);
    drain();
    set_config(cmwe_pkg::MODE_DELAY, 1'b1);
    send_item(cmwe_pkg::CMD_TICK, 0, 0, 0, 63);
    send_item(cmwe_pkg::CMD_TICK, 0, 0, 0, 1);
  endtask

  // full reload by random walk, then a melt with queries, ticks and stray items
  task automatic test_random_melt(input logic [1:0] mode, input logic classic);
    int d;
    int n;
    int r;
    drain();
    set_config(mode, classic);
    for (int c = 0; c < cmwe_pkg::COLUMNS; c++) begin
      if ($urandom_range(19) == 0) send_noise();
      if (c == 0 || $urandom_range(9) == 0) d = $urandom_range(15);
      else d = $urandom_range(2);
      send_item(cmwe_pkg::CMD_LOAD, c, $urandom_range(255), d, $urandom_range(63));
    end
    for (int k = 0; k < 25; k++) begin
      r = $urandom_range(99);
      if (r < 65) begin
        send_item(cmwe_pkg::CMD_QUERY,
                  ($urandom_range(9) == 0) ? $urandom_range(255)
                                           : $urandom_range(cmwe_pkg::COLUMNS - 1),
                  $urandom_range(255), $urandom_range(15), $urandom_range(63));
      end else if (r < 80) begin
        r = $urandom_range(99);
        if (r < 5) n = 0;
        else if (r < 60) n = $urandom_range(3, 1);
        else if (r < 90) n = $urandom_range(16, 4);
        else n = $urandom_range(63, 17);
        send_item(cmwe_pkg::CMD_TICK, $urandom_range(255), $urandom_range(255),
                  $urandom_range(15), n);
      end else if (r < 88) begin
        send_item(cmwe_pkg::CMD_LOAD, $urandom_range(255), $urandom_range(255),
                  $urandom_range(15), $urandom_range(63));
      end else begin
        send_noise();
      end
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    melt_result_t got;
    melt_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[9:0];
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.done !== want.done) begin
          $display("%0t: done_res expected %0d got %0d", $time, want.done, got.done);
          mismatches++;
        end
        if (got.from_end !== want.from_end) begin
          $display("%0t: from_end_screen expected %0d got %0d",
                   $time, want.from_end, got.from_end);
          mismatches++;
        end
        if (got.src_row !== want.src_row) begin
          $display("%0t: source_row expected %0d got %0d", $time, want.src_row, got.src_row);
          mismatches++;
        end
      end
    end
  end

  // a long tick holds every channel quiet for up to 63 passes over the columns
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 34;
    snk_idle_pct = 59;
    test_unloaded_safe();
    test_walk_clamps();
    test_query_edges();
    test_mode_ticks();
    test_random_melt(cmwe_pkg::MODE_MELT, 1'b0);
    test_random_melt(cmwe_pkg::MODE_DELAY, 1'b0);

    src_idle_pct = 59;
    snk_idle_pct = 34;
    test_random_melt(cmwe_pkg::MODE_OFF, 1'b1);
    test_random_melt(MODE_UNUSED, 1'b0);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_melt(cmwe_pkg::MODE_DELAY, 1'b1);
    test_random_melt(cmwe_pkg::MODE_OFF, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/cmwe_pkg.sv
rtl/column_melt_wipe_engine_unit.sv
tb/tb_top.sv
